/* rtl/wildcard_glob_matcher_defines.svh */
// assertion macros for the glob matcher
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define WGM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wgm assertion failed");
// checked at every edge, reset included
`define WGM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wgm assertion failed");
`else
`define WGM_ASSERT(lbl, prop)
`define WGM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/wgm_pkg.sv */
package wgm_pkg;

  localparam int WGM_MAX_PATTERN = 64;

  localparam logic [7:0] STAR_CHAR = 8'd42;
  localparam logic [7:0] ANY_CHAR  = 8'd63;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_SUBJECT = 2'd2,
    MODE_END     = 2'd3
  } mode_t;

  // per-cell control decoded at the top level
  typedef struct packed {
    logic update;  // active bits take a new value this cycle
    logic subj;    // subject byte step, otherwise rearm
    logic wr;      // this cell takes the appended pattern byte
    logic valid;   // cell lies inside the (new) pattern length
  } cell_ctrl_t;

endpackage

/* rtl/wgm_cell.sv */
module wgm_cell
  import wgm_pkg::*;
#(
  parameter bit ACT_RST = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] ch,
  input  logic       step_in,
  input  logic       carry_in,
  output logic       step_out,
  output logic       carry_out,
  output logic       act_o
);

  logic [7:0] p_r;
  logic [7:0] p_eff;
  logic       act_r, act_nxt;
  logic       is_star, is_any, pre;

  // an appended byte is seen by the rearm in the same cycle
  assign p_eff   = ctrl.wr ? ch : p_r;
  assign is_star = (p_eff == STAR_CHAR);
  assign is_any  = (p_eff == ANY_CHAR);

  // a star keeps its own position alive on a subject byte
  assign pre = (ctrl.subj & act_r & is_star & ctrl.valid) | step_in;

  always_comb begin
    act_nxt = act_r;
    if (ctrl.update) begin
      act_nxt = pre | carry_in;
    end
  end

  // star closure ripples right through the chain
  assign carry_out = act_nxt & is_star & ctrl.valid;
  assign step_out  = ctrl.subj & act_r & ctrl.valid & ~is_star &
                     (is_any | (p_eff == ch));
  assign act_o     = act_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      p_r <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_RST;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

/* rtl/wildcard_glob_matcher.sv */
// Glob matcher: a row of MAX_PATTERN cells, one per pattern byte, each holding its byte and
// the active bit of its position; a final position bit sits past the last cell. A new word
// is accepted in every cycle while the result register is free or being drained: clear
// (mode 0), append a pattern byte (mode 1), subject byte (mode 2) or end of subject (mode 3),
// which gives one result word in the result register the cycle after it is taken and rearms
// the row. '*' matches any run, '?' any one byte; an append past MAX_PATTERN bytes sets
// overflow and forces matched low until the next clear. The clock period is set by the star
// closure, which ripples combinationally through all cells like a carry chain.
`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = WGM_MAX_PATTERN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_overflow
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  mode_t           mode;
  logic            acc;
  logic            full;
  logic [LenW-1:0] len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            upd, subj, wr;
  logic            hit;
  logic            end_act_r;
  logic            out_valid_r, out_matched_r, out_overflow_r;

  logic [MAX_PATTERN:0] step_c;
  logic [MAX_PATTERN:0] carry_c;
  logic [MAX_PATTERN:0] act_vec;

  assign mode     = mode_t'(in_mode);
  assign in_ready = ~out_valid_r | out_ready;
  assign acc      = in_valid & in_ready;
  assign full     = (len_r == LenW'(MAX_PATTERN));

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    upd     = 1'b0;
    subj    = 1'b0;
    wr      = 1'b0;
    if (acc) begin
      upd = 1'b1;
      unique case (mode)
        MODE_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end
        MODE_APPEND: begin
          if (!full) begin
            len_nxt = len_r + 1'b1;
            wr      = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        MODE_SUBJECT: begin
          subj = 1'b1;
        end
        MODE_END: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // rearm seeds position zero
  assign step_c[0]  = upd & ~subj;
  assign carry_c[0] = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.update = upd;
    assign ctrl.subj   = subj;
    assign ctrl.wr     = wr & (len_r == LenW'(i));
    assign ctrl.valid  = (LenW'(i) < len_nxt);

    wgm_cell #(
      .ACT_RST (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .ch        (in_char_value),
      .step_in   (step_c[i]),
      .carry_in  (carry_c[i]),
      .step_out  (step_c[i+1]),
      .carry_out (carry_c[i+1]),
      .act_o     (act_vec[i])
    );
  end

  // position past the last cell holds no byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_act_r <= 1'b0;
    end else if (upd) begin
      end_act_r <= step_c[MAX_PATTERN] | carry_c[MAX_PATTERN];
    end
  end

  assign act_vec[MAX_PATTERN] = end_act_r;
  assign hit = act_vec[len_r] & ~ovf_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && mode == MODE_END) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && mode == MODE_END) begin
      out_matched_r  <= hit;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

  `WGM_ASSERT(a_word_from_end, $rose(out_valid_r) |-> $past(acc && mode == MODE_END))
  `WGM_ASSERT(a_ovf_no_match, out_valid_r && out_overflow_r |-> !out_matched_r)
  `WGM_ASSERT(a_clear_rearms, acc && mode == MODE_CLEAR |=> act_vec[0] && len_r == '0)
  `WGM_ASSERT_ALWAYS(a_len_bound, !rst_n || len_r <= LenW'(MAX_PATTERN))

endmodule
